FILE: sv/tsbp_pkg.sv
package tsbp_pkg;

  // Register indexes on the configuration channel
  localparam int CfgIndexWidth = 2;
  localparam logic [CfgIndexWidth-1:0] REG_START_BYTE   = 2'd0;
  localparam logic [CfgIndexWidth-1:0] REG_END_BYTE     = 2'd1;
  localparam logic [CfgIndexWidth-1:0] REG_SYNC_COMMAND = 2'd2;

  localparam logic [7:0] START_BYTE_RESET   = 8'd170;
  localparam logic [7:0] END_BYTE_RESET     = 8'd85;
  localparam logic [7:0] SYNC_COMMAND_RESET = 8'd1;

  // Characters of the text form
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [6:0] HOUR_MAX   = 7'd23;
  localparam logic [6:0] MINUTE_MAX = 7'd59;
  localparam logic [6:0] SECOND_MAX = 7'd59;
  localparam logic [6:0] DIGIT_WEIGHT = 7'd10;

  // Frame layout: start, command, length, then payload from position 3
  localparam logic [8:0] FRAME_HDR  = 9'd3;
  localparam logic [8:0] TIME_BYTES = 9'd3;
  localparam logic [7:0] SYNC_LEN   = 8'd7;

  typedef enum logic [3:0] {
    TS_IDLE = 4'd0,
    TS_H1   = 4'd1,
    TS_H2   = 4'd2,
    TS_C1   = 4'd3,
    TS_M1   = 4'd4,
    TS_M2   = 4'd5,
    TS_C2   = 4'd6,
    TS_S1   = 4'd7,
    TS_S2   = 4'd8
  } text_state_t;

  typedef struct packed {
    logic [7:0] hour_value;
    logic [7:0] minute_value;
    logic [7:0] second_value;
    logic       from_frame;
  } result_t;

endpackage

FILE: sv/tsbp_if.sv
// Received byte channel
interface tsbp_byte_if import tsbp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Time sync result channel
interface tsbp_time_if import tsbp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] hour_value;
  logic [7:0] minute_value;
  logic [7:0] second_value;
  logic       from_frame;

  modport source (output valid, output hour_value, output minute_value,
                  output second_value, output from_frame, input ready);
  modport sink   (input valid, input hour_value, input minute_value,
                  input second_value, input from_frame, output ready);
endinterface

// Configuration write channel
interface tsbp_cfg_if import tsbp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CfgIndexWidth-1:0] index;
  logic [7:0]               data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/time_sync_byte_parser_core.sv
// Time sync byte parser. Each received byte word feeds a text parser
// ("THH:M", "THH:MM" or "THH:MM:SS"; two-digit fields range checked)
// and a binary frame parser (start, command, length, payload, XOR
// checksum, end) at the same time; a time sync frame of length 7
// reports its first three payload bytes raw, and wins when both parsers
// finish on the same byte. Throughput is one byte per clock while
// rx.ready is high: the whole step is a single pass of logic from the
// parser state to a result register. The output holds two words (a
// result register and a skid register), so rx stays ready while one
// result waits; rx.ready drops only while both are full. The
// configuration channel is always ready; write it only while idle.
// Indexes beyond the register list are ignored.
module time_sync_byte_parser_core import tsbp_pkg::*; (
  input logic            clk,
  input logic            rst,
  tsbp_byte_if.sink      rx,
  tsbp_time_if.source    sync,
  tsbp_cfg_if.sink       cfg
);

  // Configuration registers
  logic [7:0] start_byte;
  logic [7:0] end_byte;
  logic [7:0] sync_command;

  // Text parser state
  text_state_t text_state, text_state_next;
  logic [6:0]  text_hour, text_hour_next;
  logic [6:0]  text_minute, text_minute_next;
  logic [6:0]  text_second, text_second_next;
  logic        text_done;

  // Frame parser state
  logic [8:0] frame_position, frame_position_next;
  logic [7:0] frame_command, frame_command_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] running_xor, running_xor_next;
  logic [7:0] received_check, received_check_next;
  logic [7:0] payload_time [3];
  logic       payload_we;
  logic [1:0] payload_slot;
  logic       frame_done;

  // Output register and skid register
  logic    out_valid;
  result_t out_word;
  logic    skid_valid;
  result_t skid_word;

  logic       accept;
  logic       pop;
  result_t    result;
  logic [7:0] b;
  logic       is_digit;
  logic [6:0] digit;
  logic [6:0] tens;
  logic [6:0] units_sum_hour;
  logic [6:0] units_sum_minute;
  logic [6:0] units_sum_second;
  text_state_t fallback;
  logic [8:0] check_pos;
  logic [8:0] payload_offset;

  assign cfg.ready = 1'b1;
  assign rx.ready  = !skid_valid;
  assign accept    = rx.valid && rx.ready;
  assign pop       = out_valid && sync.ready;

  assign b        = rx.rx_byte;
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign digit    = {3'b000, b[3:0]};
  assign tens     = 7'(digit * DIGIT_WEIGHT);
  assign units_sum_hour   = text_hour + digit;
  assign units_sum_minute = text_minute + digit;
  assign units_sum_second = text_second + digit;
  // A byte that breaks the parse restarts it when it is 'T'
  assign fallback = (b == CH_T) ? TS_H1 : TS_IDLE;

  // Text parser: next state and completion
  always_comb begin
    text_state_next  = text_state;
    text_hour_next   = text_hour;
    text_minute_next = text_minute;
    text_second_next = text_second;
    text_done        = 1'b0;
    unique case (text_state)
      TS_H1: begin
        if (is_digit) begin
          text_hour_next  = tens;
          text_state_next = TS_H2;
        end else begin
          text_state_next = fallback;
        end
      end
      TS_H2: begin
        if (is_digit) begin
          text_hour_next  = units_sum_hour;
          text_state_next = (units_sum_hour <= HOUR_MAX) ? TS_C1 : TS_IDLE;
        end else begin
          text_state_next = fallback;
        end
      end
      TS_C1: begin
        text_state_next = (b == CH_COLON) ? TS_M1 : fallback;
      end
      TS_M1: begin
        if (is_digit) begin
          text_minute_next = tens;
          text_state_next  = TS_M2;
        end else begin
          text_state_next = fallback;
        end
      end
      TS_M2: begin
        if (is_digit) begin
          text_minute_next = units_sum_minute;
          text_state_next  = (units_sum_minute <= MINUTE_MAX) ? TS_C2 : TS_IDLE;
        end else begin
          // Short minutes: complete with the tens digit alone
          text_second_next = '0;
          text_done        = 1'b1;
          text_state_next  = fallback;
        end
      end
      TS_C2: begin
        if (b == CH_COLON) begin
          text_state_next = TS_S1;
        end else begin
          text_second_next = '0;
          text_done        = 1'b1;
          text_state_next  = fallback;
        end
      end
      TS_S1: begin
        if (is_digit) begin
          text_second_next = tens;
          text_state_next  = TS_S2;
        end else begin
          text_state_next = fallback;
        end
      end
      TS_S2: begin
        // Always drop to idle here, even on 'T'
        text_state_next = TS_IDLE;
        if (is_digit) begin
          text_second_next = units_sum_second;
          text_done        = (units_sum_second <= SECOND_MAX);
        end
      end
      default: begin
        text_state_next = fallback;
      end
    endcase
  end

  assign check_pos      = FRAME_HDR + {1'b0, frame_length};
  assign payload_offset = frame_position - FRAME_HDR;

  // Frame parser: keep a running XOR, capture only the three time bytes
  always_comb begin
    frame_position_next = frame_position;
    frame_command_next  = frame_command;
    frame_length_next   = frame_length;
    running_xor_next    = running_xor;
    received_check_next = received_check;
    payload_we          = 1'b0;
    payload_slot        = payload_offset[1:0];
    frame_done          = 1'b0;
    priority if (frame_position == 9'd0) begin
      if (b == start_byte) frame_position_next = 9'd1;
    end else if (frame_position == 9'd1) begin
      frame_command_next  = b;
      running_xor_next    = b;
      frame_position_next = 9'd2;
    end else if (frame_position == 9'd2) begin
      frame_length_next   = b;
      running_xor_next    = running_xor ^ b;
      frame_position_next = FRAME_HDR;
    end else if (frame_position < check_pos) begin
      payload_we          = (frame_position < FRAME_HDR + TIME_BYTES);
      running_xor_next    = running_xor ^ b;
      frame_position_next = frame_position + 9'd1;
    end else if (frame_position == check_pos) begin
      received_check_next = b;
      frame_position_next = frame_position + 9'd1;
    end else begin
      // End byte position: judge the frame, never reuse the byte as a start
      frame_done = (b == end_byte) && (running_xor == received_check) &&
                   (frame_command == sync_command) && (frame_length == SYNC_LEN);
      frame_position_next = 9'd0;
      frame_length_next   = '0;
    end
  end

  // The frame result takes priority over a text result on the same byte
  always_comb begin
    if (frame_done) begin
      result.hour_value   = payload_time[0];
      result.minute_value = payload_time[1];
      result.second_value = payload_time[2];
      result.from_frame   = 1'b1;
    end else begin
      result.hour_value   = {1'b0, text_hour_next};
      result.minute_value = {1'b0, text_minute_next};
      result.second_value = {1'b0, text_second_next};
      result.from_frame   = 1'b0;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte   <= START_BYTE_RESET;
      end_byte     <= END_BYTE_RESET;
      sync_command <= SYNC_COMMAND_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_START_BYTE:   start_byte   <= cfg.data;
        REG_END_BYTE:     end_byte     <= cfg.data;
        REG_SYNC_COMMAND: sync_command <= cfg.data;
        default: ;
      endcase
    end
  end

  // Parser state: advance on every accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      text_state     <= TS_IDLE;
      text_hour      <= '0;
      text_minute    <= '0;
      text_second    <= '0;
      frame_position <= '0;
      frame_command  <= '0;
      frame_length   <= '0;
      running_xor    <= '0;
      received_check <= '0;
      payload_time   <= '{default: '0};
    end else if (accept) begin
      text_state     <= text_state_next;
      text_hour      <= text_hour_next;
      text_minute    <= text_minute_next;
      text_second    <= text_second_next;
      frame_position <= frame_position_next;
      frame_command  <= frame_command_next;
      frame_length   <= frame_length_next;
      running_xor    <= running_xor_next;
      received_check <= received_check_next;
      if (payload_we) payload_time[payload_slot] <= b;
    end
  end

  // Result register with skid: hold a second word while the first waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= accept && (frame_done || text_done);
        end
      end else if (!out_valid) begin
        out_valid <= accept && (frame_done || text_done);
      end else if (accept && (frame_done || text_done)) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      out_word <= skid_word;
    end else if (pop || !out_valid) begin
      out_word <= result;
    end
    if (!pop && out_valid && !skid_valid) begin
      skid_word <= result;
    end
  end

  assign sync.valid        = out_valid;
  assign sync.hour_value   = out_word.hour_value;
  assign sync.minute_value = out_word.minute_value;
  assign sync.second_value = out_word.second_value;
  assign sync.from_frame   = out_word.from_frame;

endmodule

FILE: tb/sv/tb.sv
module tb;
  import tsbp_pkg::*;

  // Index 3 fits the index field but names no register; the block must drop it.
  localparam logic [CfgIndexWidth-1:0] REG_UNUSED = 2'd3;

  localparam int PHASE_BYTES   = 215;
  localparam int PHASE_COUNT   = 6;
  localparam int LONG_HOLD     = 80;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int MAX_REPORTS   = 100;
  localparam result_t NO_SYNC  = '0;

  // One byte word of stimulus; fixed rows carry a time word read straight off the spec.
  typedef struct packed {
    logic [7:0] value;
    logic       fixed;
    result_t    sync;
  } row_t;

  typedef enum logic [2:0] {
    BURST_TEXT,
    BURST_FRAME,
    BURST_LONG_FRAME,
    BURST_OVERLAP,
    BURST_NOISE
  } burst_kind_t;

  logic clk = 1'b0;
  logic rst;

  tsbp_byte_if rx_ch ();
  tsbp_time_if sync_ch ();
  tsbp_cfg_if  cfg_ch ();

  time_sync_byte_parser_core dut (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx_ch),
    .sync (sync_ch),
    .cfg  (cfg_ch)
  );

  // Mirror of the parser: register copies, text parser and frame parser state.
  logic [7:0]  cfg_start, cfg_end, cfg_cmd;
  text_state_t txt_state;
  logic [6:0]  txt_hour, txt_minute, txt_second;
  logic [8:0]  frm_pos;
  logic [7:0]  frm_cmd, frm_len, frm_xor, frm_check;
  logic [7:0]  frm_time [3];

  result_t    sync_expected [$];   // time words still owed by the block, oldest first
  row_t       byte_notes [$];      // one note per offered byte, in offer order
  logic [7:0] burst [$];           // bytes of the sequence being sent

  // Values the generator builds frames with; they track what was last written.
  logic [7:0] gen_start = START_BYTE_RESET;
  logic [7:0] gen_end   = END_BYTE_RESET;
  logic [7:0] gen_cmd   = SYNC_COMMAND_RESET;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int fail_count  = 0;
  int bytes_taken = 0;
  int text_words  = 0;
  int frame_words = 0;
  int cfg_writes  = 0;
  int cycles      = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance both parsers by one byte; report whether a time word comes out and its value.
  function automatic void parse_byte(input logic [7:0] b, output logic got,
                                     output result_t r);
    logic        is_digit;
    logic [6:0]  d;
    text_state_t restart;
    logic        text_done;
    logic        frame_done;
    int          span;
    int          k;
    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    d = 7'(b - CH_ZERO);
    restart = (b == CH_T) ? TS_H1 : TS_IDLE;
    text_done = 1'b0;
    frame_done = 1'b0;

    case (txt_state)
      TS_H1: begin
        if (is_digit) begin
          txt_hour = d * DIGIT_WEIGHT;
          txt_state = TS_H2;
        end else txt_state = restart;
      end
      TS_H2: begin
        if (is_digit) begin
          txt_hour = txt_hour + d;
          txt_state = (txt_hour <= HOUR_MAX) ? TS_C1 : TS_IDLE;
        end else txt_state = restart;
      end
      TS_C1: txt_state = (b == CH_COLON) ? TS_M1 : restart;
      TS_M1: begin
        if (is_digit) begin
          txt_minute = d * DIGIT_WEIGHT;
          txt_state = TS_M2;
        end else txt_state = restart;
      end
      TS_M2: begin
        if (is_digit) begin
          txt_minute = txt_minute + d;
          txt_state = (txt_minute <= MINUTE_MAX) ? TS_C2 : TS_IDLE;
        end else begin
          // Single minute digit: complete with the tens value, no range check.
          txt_second = '0;
          text_done = 1'b1;
          txt_state = restart;
        end
      end
      TS_C2: begin
        if (b == CH_COLON) txt_state = TS_S1;
        else begin
          txt_second = '0;
          text_done = 1'b1;
          txt_state = restart;
        end
      end
      TS_S1: begin
        if (is_digit) begin
          txt_second = d * DIGIT_WEIGHT;
          txt_state = TS_S2;
        end else txt_state = restart;
      end
      TS_S2: begin
        // Last digit position never restarts, even on 'T'.
        txt_state = TS_IDLE;
        if (is_digit) begin
          txt_second = txt_second + d;
          if (txt_second <= SECOND_MAX) text_done = 1'b1;
        end
      end
      default: txt_state = restart;
    endcase

    span = int'(FRAME_HDR) + int'(frm_len);
    if (frm_pos == 9'd0) begin
      if (b == cfg_start) frm_pos = 9'd1;
    end else if (frm_pos == 9'd1) begin
      frm_cmd = b;
      frm_xor = b;
      frm_pos = 9'd2;
    end else if (frm_pos == 9'd2) begin
      frm_len = b;
      frm_xor = frm_xor ^ b;
      frm_pos = 9'd3;
    end else if (int'(frm_pos) < span) begin
      k = int'(frm_pos) - int'(FRAME_HDR);
      if (k < int'(TIME_BYTES)) frm_time[2'(k)] = b;
      frm_xor = frm_xor ^ b;
      frm_pos = frm_pos + 9'd1;
    end else if (int'(frm_pos) == span) begin
      frm_check = b;
      frm_pos = frm_pos + 9'd1;
    end else begin
      // End byte position: never taken as a new start.
      frame_done = (b == cfg_end) && (frm_xor == frm_check) &&
                   (frm_cmd == cfg_cmd) && (frm_len == SYNC_LEN);
      frm_pos = 9'd0;
      frm_len = 8'd0;
    end

    got = frame_done || text_done;
    if (frame_done) begin
      r.hour_value   = frm_time[0];
      r.minute_value = frm_time[1];
      r.second_value = frm_time[2];
      r.from_frame   = 1'b1;
    end else begin
      r.hour_value   = {1'b0, txt_hour};
      r.minute_value = {1'b0, txt_minute};
      r.second_value = {1'b0, txt_second};
      r.from_frame   = 1'b0;
    end
  endfunction

  // Track register writes and byte words, and check every time word taken from the block.
  always @(posedge clk) begin
    logic    got;
    result_t guess;
    result_t want;
    row_t    note;
    if (rst) begin
      cfg_start  = START_BYTE_RESET;
      cfg_end    = END_BYTE_RESET;
      cfg_cmd    = SYNC_COMMAND_RESET;
      txt_state  = TS_IDLE;
      txt_hour   = '0;
      txt_minute = '0;
      txt_second = '0;
      frm_pos    = '0;
      frm_cmd    = '0;
      frm_len    = '0;
      frm_xor    = '0;
      frm_check  = '0;
      frm_time[0] = '0;
      frm_time[1] = '0;
      frm_time[2] = '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        cfg_writes++;
        case (cfg_ch.index)
          REG_START_BYTE:   cfg_start = cfg_ch.data;
          REG_END_BYTE:     cfg_end   = cfg_ch.data;
          REG_SYNC_COMMAND: cfg_cmd   = cfg_ch.data;
          default: ;
        endcase
      end
      if (rx_ch.valid && rx_ch.ready) begin
        note = (byte_notes.size() != 0) ? byte_notes.pop_front()
                                        : {rx_ch.rx_byte, 1'b0, NO_SYNC};
        parse_byte(rx_ch.rx_byte, got, guess);
        bytes_taken++;
        // Fixed rows state their own word; all others rely on the mirror.
        if (note.fixed) sync_expected.push_back(note.sync);
        else if (got) sync_expected.push_back(guess);
      end
      if (sync_ch.valid && sync_ch.ready) begin
        if (sync_expected.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: unexpected time word: expected none, got h=%0d m=%0d s=%0d frame=%0b",
                     $time, sync_ch.hour_value, sync_ch.minute_value,
                     sync_ch.second_value, sync_ch.from_frame);
        end else begin
          want = sync_expected.pop_front();
          if (sync_ch.from_frame === 1'b1) frame_words++;
          else text_words++;
          if (sync_ch.hour_value !== want.hour_value ||
              sync_ch.minute_value !== want.minute_value ||
              sync_ch.second_value !== want.second_value ||
              sync_ch.from_frame !== want.from_frame) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("%0t: time word mismatch: expected h=%0d m=%0d s=%0d frame=%0b, %s",
                       $time, want.hour_value, want.minute_value, want.second_value,
                       want.from_frame,
                       $sformatf("got h=%0d m=%0d s=%0d frame=%0b",
                                 sync_ch.hour_value, sync_ch.minute_value,
                                 sync_ch.second_value, sync_ch.from_frame));
          end
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off each time the driver asks for one.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      sync_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_asks) begin
      sync_ch.ready <= 1'b0;
      hold_seen <= hold_asks;
      hold_left <= LONG_HOLD - 1;
    end else begin
      sync_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d time words outstanding",
               cycles, sync_expected.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] digit_char(input int n);
    return CH_ZERO + 8'(n);
  endfunction

  // Byte that ends a text parse early: often a restart, otherwise anything.
  function automatic logic [7:0] tail_char();
    return ($urandom_range(2) == 0) ? CH_T : 8'($urandom);
  endfunction

  // Fill the burst queue with one sequence of the given kind.
  function automatic void build_burst(input burst_kind_t kind);
    int         hr, mn, sc, len, form;
    logic [7:0] cmd, sum, pay;
    logic [7:0] body [7];
    burst.delete();
    case (kind)
      BURST_TEXT: begin
        hr = ($urandom_range(99) < 85) ? $urandom_range(23) : $urandom_range(99, 24);
        mn = ($urandom_range(99) < 85) ? $urandom_range(59) : $urandom_range(99, 60);
        sc = ($urandom_range(99) < 85) ? $urandom_range(59) : $urandom_range(99, 60);
        form = $urandom_range(3);
        burst.push_back(CH_T);
        burst.push_back(digit_char(hr / 10));
        burst.push_back(digit_char(hr % 10));
        burst.push_back(CH_COLON);
        burst.push_back(digit_char(mn / 10));
        if (form == 0) burst.push_back(tail_char());
        else begin
          burst.push_back(digit_char(mn % 10));
          if (form == 1) burst.push_back(tail_char());
          else begin
            burst.push_back(CH_COLON);
            burst.push_back(digit_char(sc / 10));
            burst.push_back(($urandom_range(9) == 0) ? 8'($urandom) : digit_char(sc % 10));
          end
        end
        // Break some sequences at a random spot.
        if ($urandom_range(99) < 12) burst[$urandom_range(burst.size() - 1)] = 8'($urandom);
      end
      BURST_FRAME, BURST_LONG_FRAME: begin
        cmd = ($urandom_range(99) < 80) ? gen_cmd : 8'($urandom);
        form = $urandom_range(199);
        if (kind == BURST_LONG_FRAME || form >= 194) len = 255;
        else if (form < 130) len = int'(SYNC_LEN);
        else len = $urandom_range(12);
        burst.push_back(gen_start);
        burst.push_back(cmd);
        burst.push_back(8'(len));
        sum = cmd ^ 8'(len);
        for (int i = 0; i < len; i++) begin
          pay = ($urandom_range(3) == 0) ? digit_char($urandom_range(9)) : 8'($urandom);
          burst.push_back(pay);
          sum = sum ^ pay;
        end
        if ($urandom_range(99) < 12) sum = sum ^ (8'd1 << $urandom_range(7));
        burst.push_back(sum);
        burst.push_back(($urandom_range(99) < 88) ? gen_end : 8'($urandom));
      end
      BURST_OVERLAP: begin
        // Valid sync frame whose tail spells "THH:MM", the last minute digit
        // being the checksum, so text and frame both finish on the end byte.
        hr = $urandom_range(23);
        mn = $urandom_range(59);
        body[0] = 8'($urandom);
        body[2] = CH_T;
        body[3] = digit_char(hr / 10);
        body[4] = digit_char(hr % 10);
        body[5] = CH_COLON;
        body[6] = digit_char(mn / 10);
        sum = digit_char(mn % 10);
        body[1] = sum ^ gen_cmd ^ SYNC_LEN ^ body[0] ^ body[2] ^ body[3] ^ body[4] ^
                  body[5] ^ body[6];
        burst.push_back(gen_start);
        burst.push_back(gen_cmd);
        burst.push_back(SYNC_LEN);
        for (int i = 0; i < 7; i++) burst.push_back(body[i]);
        burst.push_back(sum);
        burst.push_back(gen_end);
      end
      default: begin
        for (int i = $urandom_range(5); i >= 0; i--) begin
          form = $urandom_range(99);
          if (form < 40) burst.push_back(8'($urandom));
          else if (form < 60) burst.push_back(CH_T);
          else if (form < 75) burst.push_back(CH_COLON);
          else if (form < 90) burst.push_back(digit_char($urandom_range(9)));
          else burst.push_back(gen_start);
        end
      end
    endcase
  endfunction

  // Offer one byte word after a random gap; return once the block takes it.
  task automatic offer_byte(input row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_notes.push_back(row);
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= row.value;
    do @(posedge clk); while (rx_ch.ready !== 1'b1);
  endtask

  // Drop valid and wait until every owed time word has been taken.
  task automatic drain();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (sync_expected.size() != 0) @(posedge clk);
  endtask

  // Hold a register write until taken; the caller drops valid after the last one.
  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input logic [7:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
  endtask

  initial begin
    row_t        opening [26];
    burst_kind_t kind;
    int          sent;
    int          pick;
    bit          paused;

    rst           <= 1'b1;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= 8'd0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= REG_START_BYTE;
    cfg_ch.data   <= 8'd0;

    // Directed opening under reset values: short minutes completed by a start
    // byte, a sync frame with extreme payload bytes, then the largest text time.
    opening = '{
      {CH_T,     1'b0, NO_SYNC},
      {"0",      1'b0, NO_SYNC},
      {"0",      1'b0, NO_SYNC},
      {CH_COLON, 1'b0, NO_SYNC},
      {"9",      1'b0, NO_SYNC},
      {8'hAA,    1'b1, 8'd0, 8'd90, 8'd0, 1'b0},
      {8'h01,    1'b0, NO_SYNC},
      {8'h07,    1'b0, NO_SYNC},
      {8'hFF,    1'b0, NO_SYNC},
      {8'h00,    1'b0, NO_SYNC},
      {8'h80,    1'b0, NO_SYNC},
      {8'h00,    1'b0, NO_SYNC},
      {8'h00,    1'b0, NO_SYNC},
      {8'h00,    1'b0, NO_SYNC},
      {8'h00,    1'b0, NO_SYNC},
      {8'h79,    1'b0, NO_SYNC},
      {8'h55,    1'b1, 8'hFF, 8'h00, 8'h80, 1'b1},
      {CH_T,     1'b0, NO_SYNC},
      {"2",      1'b0, NO_SYNC},
      {"3",      1'b0, NO_SYNC},
      {CH_COLON, 1'b0, NO_SYNC},
      {"5",      1'b0, NO_SYNC},
      {"9",      1'b0, NO_SYNC},
      {CH_COLON, 1'b0, NO_SYNC},
      {"5",      1'b0, NO_SYNC},
      {"9",      1'b1, 8'd23, 8'd59, 8'd59, 1'b0}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      // Settle before touching registers: no word owed, pipeline empty.
      drain();
      repeat (SETTLE_CYCLES) @(posedge clk);

      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct <= 0;
        end
        1: begin
          gen_start = 8'h00; gen_end = 8'hFF; gen_cmd = 8'h00;
          send_idle_pct = 61;
          recv_stall_pct <= 0;
        end
        2: begin
          gen_start = 8'hFF; gen_end = 8'h00; gen_cmd = 8'hFF;
          send_idle_pct = 0;
          recv_stall_pct <= 61;
        end
        3: begin
          gen_start = 8'($urandom); gen_end = 8'($urandom); gen_cmd = 8'($urandom);
          send_idle_pct = 24;
          recv_stall_pct <= 24;
        end
        4: begin
          gen_start = START_BYTE_RESET; gen_end = END_BYTE_RESET;
          gen_cmd = SYNC_COMMAND_RESET;
          send_idle_pct = 0;
          recv_stall_pct <= 0;
        end
        default: begin
          gen_start = CH_T; gen_end = 8'($urandom); gen_cmd = 8'($urandom);
          send_idle_pct = 24;
          recv_stall_pct <= 24;
        end
      endcase

      if (ph > 0) begin
        write_reg(REG_START_BYTE, gen_start);
        write_reg(REG_END_BYTE, gen_end);
        write_reg(REG_SYNC_COMMAND, gen_cmd);
        // Poke the unused index; the mirror ignores it, so must the block.
        if (ph == 2 || ph == 5) write_reg(REG_UNUSED, 8'($urandom));
        cfg_ch.valid <= 1'b0;
      end

      if (ph == 0) foreach (opening[i]) offer_byte(opening[i]);

      // Hold off the receiver while a run of text syncs keeps coming, so the
      // output fills and rx backs up.
      if (ph == 4) hold_asks <= hold_asks + 1;

      sent = 0;
      paused = 1'b0;
      while (sent < PHASE_BYTES) begin
        // Pause the sender once until every owed word has come out.
        if (ph == 5 && !paused && sent >= PHASE_BYTES / 2) begin
          drain();
          paused = 1'b1;
        end
        pick = $urandom_range(99);
        if (ph == 1 && sent == 0) kind = BURST_LONG_FRAME;
        else if (ph == 4 && sent < LONG_HOLD) kind = BURST_TEXT;
        else if (pick < 35) kind = BURST_TEXT;
        else if (pick < 70) kind = BURST_FRAME;
        else if (pick < 80) kind = BURST_OVERLAP;
        else kind = BURST_NOISE;
        build_burst(kind);
        foreach (burst[i]) begin
          offer_byte({burst[i], 1'b0, NO_SYNC});
          sent++;
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d bytes over %0d register settings and %0d register writes;",
             bytes_taken, PHASE_COUNT, cfg_writes);
    $display("checked %0d text and %0d frame time words under idle, stall and hold-off.",
             text_words, frame_words);
    if (fail_count == 0 && sync_expected.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/tsbp_pkg.sv
sv/tsbp_if.sv
sv/time_sync_byte_parser_core.sv
tb/sv/tb.sv
